### hw/rtl/frame_sync_delay_adjuster_assert.svh
// Assertion macros used by the checker of the frame sync delay adjuster.
`ifndef FRAME_SYNC_DELAY_ADJUSTER_ASSERT_SVH
`define FRAME_SYNC_DELAY_ADJUSTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fsda assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FSDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fsda assertion failed");

`endif

### hw/rtl/fsda_pkg.sv
// Types, constants and register map of the frame sync delay adjuster.
package fsda_pkg;

	localparam int FrameW = 24;
	localparam int SkipW = FrameW + 1;
	localparam int DiffW = FrameW + 1;
	localparam int AdjW = DiffW + 1;
	localparam int PeriodW = 20;
	localparam int QuotW = 14;
	localparam int RateW = 8;
	localparam int OffsetW = AdjW + QuotW + 1;
	localparam int CalcW = OffsetW + 1;
	localparam int FloorW = PeriodW + 1;

	localparam int InDataW = 48;
	localparam int OutDataW = 56;
	localparam int AddrW = 4;
	localparam int DataW = 32;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] RegSeqPeriod = 2'd0;
	localparam logic [1:0] RegBridgePeriod = 2'd1;
	localparam logic [1:0] RegRefreshRate = 2'd2;
	localparam logic [1:0] RegMultisync = 2'd3;

	localparam logic [PeriodW-1:0] SeqPeriodReset = 20'd50000;
	localparam logic [PeriodW-1:0] BridgePeriodReset = 20'd0;
	localparam logic [RateW-1:0] RefreshRateReset = 8'd20;
	localparam logic [FrameW-1:0] PeriodNowReset = 24'd50000;
	localparam logic [FrameW-1:0] PeriodMax = 24'hFFFFFF;

	localparam logic [QuotW-1:0] SeqQuotReset = 14'd500;
	localparam logic [QuotW-1:0] BridgeQuotReset = 14'd0;

	// x / 100 for any 20-bit x is (x * Div100Mult) >> Div100Shift.
	localparam int Div100Shift = 27;
	localparam logic [20:0] Div100Mult = 21'd1342178;

	localparam logic signed [DiffW-1:0] StepSkip = 25'sd4;
	localparam logic signed [DiffW-1:0] HoldLimit = 25'sd2;
	localparam logic signed [FloorW-1:0] FloorSpan = 21'sd15000;

	typedef enum logic [1:0] {
		MODE_DEFAULT = 2'd0,
		MODE_CAP = 2'd1,
		MODE_RAISE = 2'd2,
		MODE_STEP = 2'd3
	} mode_t;

	typedef struct packed {
		logic [PeriodW-1:0] seq_period;
		logic [PeriodW-1:0] bridge_period;
		logic [RateW-1:0] refresh_rate;
		logic multisync;
		logic [QuotW-1:0] seq_quot;
		logic [QuotW-1:0] bridge_quot;
	} cfg_t;

	typedef struct packed {
		logic skip_set;
		logic signed [SkipW-1:0] frame_skip;
		mode_t mode;
		logic ahead;
		logic signed [OffsetW-1:0] offset;
		logic [PeriodW-1:0] deflt;
		logic signed [FloorW-1:0] floor_val;
	} decision_t;

endpackage

### hw/rtl/fsda_cfg.sv
// Configuration registers with their APB-style port and the period quotients.
module fsda_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [fsda_pkg::AddrW-1:0] paddr,
	input  logic [fsda_pkg::DataW-1:0] pwdata,
	output logic [fsda_pkg::DataW-1:0] prdata,
	output fsda_pkg::cfg_t cfg
);

	logic [fsda_pkg::PeriodW-1:0] seq_period_q;
	logic [fsda_pkg::PeriodW-1:0] bridge_period_q;
	logic [fsda_pkg::RateW-1:0] refresh_rate_q;
	logic multisync_q;
	logic [fsda_pkg::QuotW-1:0] seq_quot_q;
	logic [fsda_pkg::QuotW-1:0] bridge_quot_q;
	logic [40:0] seq_prod;
	logic [40:0] bridge_prod;
	logic wr_en;
	logic [1:0] reg_idx;

	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_period_q <= fsda_pkg::SeqPeriodReset;
			bridge_period_q <= fsda_pkg::BridgePeriodReset;
			refresh_rate_q <= fsda_pkg::RefreshRateReset;
			multisync_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				fsda_pkg::RegSeqPeriod: seq_period_q <= pwdata[fsda_pkg::PeriodW-1:0];
				fsda_pkg::RegBridgePeriod: bridge_period_q <= pwdata[fsda_pkg::PeriodW-1:0];
				fsda_pkg::RegRefreshRate: refresh_rate_q <= pwdata[fsda_pkg::RateW-1:0];
				fsda_pkg::RegMultisync: multisync_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// The per-hundred quotients follow the period registers in the next cycle, in time
	// for an item accepted after the write to see them when it reaches the multiplier.
	assign seq_prod = 41'(seq_period_q) * 41'(fsda_pkg::Div100Mult);
	assign bridge_prod = 41'(bridge_period_q) * 41'(fsda_pkg::Div100Mult);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_quot_q <= fsda_pkg::SeqQuotReset;
			bridge_quot_q <= fsda_pkg::BridgeQuotReset;
		end else begin
			seq_quot_q <= seq_prod[fsda_pkg::Div100Shift +: fsda_pkg::QuotW];
			bridge_quot_q <= bridge_prod[fsda_pkg::Div100Shift +: fsda_pkg::QuotW];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			fsda_pkg::RegSeqPeriod: prdata = 32'(seq_period_q);
			fsda_pkg::RegBridgePeriod: prdata = 32'(bridge_period_q);
			fsda_pkg::RegRefreshRate: prdata = 32'(refresh_rate_q);
			fsda_pkg::RegMultisync: prdata = 32'(multisync_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.seq_period = seq_period_q;
	assign cfg.bridge_period = bridge_period_q;
	assign cfg.refresh_rate = refresh_rate_q;
	assign cfg.multisync = multisync_q;
	assign cfg.seq_quot = seq_quot_q;
	assign cfg.bridge_quot = bridge_quot_q;

endmodule

### hw/rtl/fsda_decide.sv
// Input register and decision stage: skip or hold choice and the period offset.
module fsda_decide (
	input  logic clk,
	input  logic arst_n,
	input  fsda_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  logic [fsda_pkg::FrameW-1:0] frame_now,
	input  logic [fsda_pkg::FrameW-1:0] frame_expected,
	input  logic sequence_running,
	output logic dec_valid,
	input  logic dec_ready,
	output fsda_pkg::decision_t dec
);

	logic valid_s1;
	logic [fsda_pkg::FrameW-1:0] now_s1;
	logic [fsda_pkg::FrameW-1:0] exp_s1;
	logic run_s1;
	logic valid_s2;
	fsda_pkg::decision_t dec_s2;
	logic adv_s2;

	logic signed [fsda_pkg::DiffW-1:0] diff;
	logic signed [fsda_pkg::AdjW-1:0] diff_x2;
	logic signed [fsda_pkg::AdjW-1:0] neg_rate;
	logic signed [fsda_pkg::AdjW-1:0] adj;
	logic [fsda_pkg::QuotW-1:0] quot;
	logic done;
	fsda_pkg::decision_t dec_c;

	assign adv_s2 = !valid_s2 || dec_ready;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			now_s1 <= frame_now;
			exp_s1 <= frame_expected;
			run_s1 <= sequence_running;
		end
		if (adv_s2 && valid_s1)
			dec_s2 <= dec_c;
	end

	always_comb begin
		diff = $signed({1'b0, now_s1}) - $signed({1'b0, exp_s1});
		diff_x2 = {diff, 1'b0};
		neg_rate = -$signed({{(fsda_pkg::AdjW-fsda_pkg::RateW){1'b0}}, cfg.refresh_rate});
		adj = {diff[fsda_pkg::DiffW-1], diff};
		done = 1'b0;
		dec_c.skip_set = 1'b0;
		dec_c.frame_skip = '0;
		if (!cfg.multisync) begin
			if (diff < -fsda_pkg::StepSkip) begin
				dec_c.skip_set = 1'b1;
				// Within half a second of lag a fixed four-frame skip is enough.
				if (diff_x2 > neg_rate) begin
					dec_c.frame_skip = fsda_pkg::StepSkip;
					adj = adj + 26'sd4;
				end else begin
					dec_c.frame_skip = -diff;
					done = 1'b1;
				end
			end else if (diff > fsda_pkg::HoldLimit) begin
				dec_c.skip_set = 1'b1;
				dec_c.frame_skip = -25'sd1;
				adj = adj - 26'sd1;
			end
		end

		if (done || adj == 26'sd0)
			dec_c.mode = fsda_pkg::MODE_DEFAULT;
		else if (adj == -26'sd1)
			dec_c.mode = fsda_pkg::MODE_CAP;
		else if (adj == 26'sd1)
			dec_c.mode = fsda_pkg::MODE_RAISE;
		else
			dec_c.mode = fsda_pkg::MODE_STEP;

		// The snap direction follows the raw difference, not the adjusted one.
		dec_c.ahead = now_s1 > exp_s1;
		dec_c.deflt = run_s1 ? cfg.seq_period : cfg.bridge_period;
		quot = run_s1 ? cfg.seq_quot : cfg.bridge_quot;
		dec_c.offset = fsda_pkg::OffsetW'(adj) * fsda_pkg::OffsetW'($signed({1'b0, quot}));
		dec_c.floor_val = $signed({1'b0, dec_c.deflt}) - fsda_pkg::FloorSpan;
	end

	assign dec_valid = valid_s2;
	assign dec = dec_s2;

endmodule

### hw/rtl/fsda_update.sv
// Period state update, saturation and the result register.
module fsda_update (
	input  logic clk,
	input  logic arst_n,
	input  logic dec_valid,
	output logic dec_ready,
	input  fsda_pkg::decision_t dec,
	output logic out_valid,
	input  logic out_ready,
	output logic skip_set,
	output logic signed [fsda_pkg::SkipW-1:0] frame_skip,
	output logic [fsda_pkg::FrameW-1:0] frame_period_us
);

	logic [fsda_pkg::FrameW-1:0] period_q;
	logic valid_q;
	logic skip_set_q;
	logic signed [fsda_pkg::SkipW-1:0] frame_skip_q;
	logic [fsda_pkg::FrameW-1:0] period_out_q;

	logic signed [fsda_pkg::CalcW-1:0] cur;
	logic signed [fsda_pkg::CalcW-1:0] deflt;
	logic signed [fsda_pkg::CalcW-1:0] floor_val;
	logic signed [fsda_pkg::CalcW-1:0] stepped;
	logic signed [fsda_pkg::CalcW-1:0] nxt;
	logic [fsda_pkg::FrameW-1:0] sat;
	logic take;

	assign dec_ready = !valid_q || out_ready;
	assign take = dec_valid && dec_ready;

	always_comb begin
		cur = $signed({{(fsda_pkg::CalcW-fsda_pkg::FrameW){1'b0}}, period_q});
		deflt = $signed({{(fsda_pkg::CalcW-fsda_pkg::PeriodW){1'b0}}, dec.deflt});
		floor_val = fsda_pkg::CalcW'(dec.floor_val);
		stepped = cur + fsda_pkg::CalcW'(dec.offset);
		// A current period already on the wrong side of the default snaps back to it.
		if (dec.ahead) begin
			if (cur < deflt)
				stepped = deflt;
		end else begin
			if (cur > deflt)
				stepped = deflt;
		end
		nxt = cur;
		unique case (dec.mode)
			fsda_pkg::MODE_DEFAULT: nxt = deflt;
			fsda_pkg::MODE_CAP: nxt = (cur > deflt) ? deflt : cur;
			fsda_pkg::MODE_RAISE: nxt = (cur < deflt) ? deflt : cur;
			fsda_pkg::MODE_STEP: nxt = (floor_val > stepped) ? floor_val : stepped;
			default: nxt = cur;
		endcase
		if (nxt < 0)
			sat = '0;
		else if (nxt > $signed({{(fsda_pkg::CalcW-fsda_pkg::FrameW){1'b0}}, fsda_pkg::PeriodMax}))
			sat = fsda_pkg::PeriodMax;
		else
			sat = nxt[fsda_pkg::FrameW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= fsda_pkg::PeriodNowReset;
			valid_q <= 1'b0;
		end else begin
			if (take)
				period_q <= sat;
			if (dec_ready)
				valid_q <= dec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			skip_set_q <= dec.skip_set;
			frame_skip_q <= dec.frame_skip;
			period_out_q <= sat;
		end
	end

	assign out_valid = valid_q;
	assign skip_set = skip_set_q;
	assign frame_skip = frame_skip_q;
	assign frame_period_us = period_out_q;

endmodule

### hw/rtl/frame_sync_delay_adjuster.sv
// Top level of the frame sync delay adjuster.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata frame_now, frame_expected; tuser run
//  m_*      | out       | m_tvalid/m_tready  | tdata frame_skip, frame_period_us; tuser skip
//  apb      | in        | psel/penable       | four registers at byte addresses 0..12
//
// A report passes the input register, the decision stage and the result register in that
// order; one report per cycle is sustained while m_tready stays high.
// The period state is updated in the last stage, so back-to-back reports see it.
// A stalled result holds; the stages behind it keep filling until all are full.
// Reset clears the registers to their defaults and the period to 50000 us.
module frame_sync_delay_adjuster (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// [23:0] frame_now, [47:24] frame_expected
	input  logic [fsda_pkg::InDataW-1:0] s_tdata,
	// [0] sequence_running
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// [24:0] frame_skip, [48:25] frame_period_us, [55:49] zero
	output logic [fsda_pkg::OutDataW-1:0] m_tdata,
	// [0] skip_set
	output logic m_tuser,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [fsda_pkg::AddrW-1:0] paddr,
	input  logic [fsda_pkg::DataW-1:0] pwdata,
	output logic [fsda_pkg::DataW-1:0] prdata,
	output logic pready
);

	fsda_pkg::cfg_t cfg;
	fsda_pkg::decision_t dec;
	logic dec_valid;
	logic dec_ready;
	logic signed [fsda_pkg::SkipW-1:0] frame_skip;
	logic [fsda_pkg::FrameW-1:0] frame_period_us;

	assign pready = 1'b1;

	fsda_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	fsda_decide u_decide (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.frame_now(s_tdata[23:0]),
		.frame_expected(s_tdata[47:24]),
		.sequence_running(s_tuser),
		.dec_valid(dec_valid),
		.dec_ready(dec_ready),
		.dec(dec)
	);

	fsda_update u_update (
		.clk(clk),
		.arst_n(arst_n),
		.dec_valid(dec_valid),
		.dec_ready(dec_ready),
		.dec(dec),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.skip_set(m_tuser),
		.frame_skip(frame_skip),
		.frame_period_us(frame_period_us)
	);

	assign m_tdata = {7'd0, frame_period_us, frame_skip};

endmodule

### hw/rtl/fsda_checker.sv
// Port-level checker of the frame sync delay adjuster and its bind.
`include "frame_sync_delay_adjuster_assert.svh"

module fsda_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [fsda_pkg::OutDataW-1:0] m_tdata,
	input  logic m_tuser,
	input  logic pready
);

	`FSDA_ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[55:49] == 7'd0)
	`FSDA_ASSERT_IMPLY(a_no_skip_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata[24:0] == 25'd0)
	`FSDA_ASSERT_IMPLY(a_skip_nonzero, clk, arst_n, m_tvalid && m_tuser, m_tdata[24:0] != 25'd0)
	`FSDA_ASSERT_NEXT(a_out_holds, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`FSDA_ASSERT_IMPLY(a_pready_high, clk, arst_n, 1'b1, pready)

endmodule

bind frame_sync_delay_adjuster fsda_checker u_fsda_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.pready(pready)
);
